// File: hw/rtl/sieve_kth_erased_number_defines.svh
// Assertion macros shared by the sieve RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SIEVE_KTH_ERASED_NUMBER_DEFINES_SVH
`define SIEVE_KTH_ERASED_NUMBER_DEFINES_SVH

// same-cycle implication
`define SKS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sks_pkg.sv
// Package for the sieve block: widths, microcode encodings and program ROM.
// No dependencies.
`default_nettype none

package sks_pkg;

    localparam int MAX_N     = 1023;
    localparam int NUM_W     = 10;
    localparam int IDX_W     = NUM_W + 1;
    localparam int MAP_DEPTH = MAX_N + 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'd0,
        S_CLR    = 4'd1,
        S_OINIT  = 4'd2,
        S_OTEST  = 4'd3,
        S_OCHK   = 4'd4,
        S_IREAD  = 4'd5,
        S_ICHK   = 4'd6,
        S_IMARK  = 4'd7,
        S_IADV   = 4'd8,
        S_ONEXT  = 4'd9,
        S_HIT    = 4'd10,
        S_NF     = 4'd11
    } step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_OUTER_INIT,
        OP_OUTER_SEL,
        OP_INNER_RD,
        OP_MARK,
        OP_ADV,
        OP_OUTER_INC,
        OP_OUT_HIT,
        OP_OUT_NF
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_START,
        C_CLR_MORE,
        C_OUTER_GT,
        C_RD_SET,
        C_INNER_GT,
        C_HIT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic clr_more;
        logic outer_gt;
        logic rd_set;
        logic inner_gt;
        logic hit;
    } flags_t;

    function automatic ctrl_t rom_word(input step_t s);
        ctrl_t w;
        begin
            unique case (s)
                S_IDLE:  w = '{OP_LOAD,       C_NOT_START, S_IDLE};
                S_CLR:   w = '{OP_CLEAR,      C_CLR_MORE,  S_CLR};
                S_OINIT: w = '{OP_OUTER_INIT, C_NEVER,     S_IDLE};
                S_OTEST: w = '{OP_OUTER_SEL,  C_OUTER_GT,  S_NF};
                S_OCHK:  w = '{OP_NOP,        C_RD_SET,    S_ONEXT};
                S_IREAD: w = '{OP_INNER_RD,   C_INNER_GT,  S_ONEXT};
                S_ICHK:  w = '{OP_NOP,        C_RD_SET,    S_IADV};
                S_IMARK: w = '{OP_MARK,       C_HIT,       S_HIT};
                S_IADV:  w = '{OP_ADV,        C_ALWAYS,    S_IREAD};
                S_ONEXT: w = '{OP_OUTER_INC,  C_ALWAYS,    S_OTEST};
                S_HIT:   w = '{OP_OUT_HIT,    C_ALWAYS,    S_IDLE};
                S_NF:    w = '{OP_OUT_NF,     C_ALWAYS,    S_IDLE};
                default: w = '{OP_NOP,        C_ALWAYS,    S_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sks_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module sks_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sks_seq.sv
// Microcode sequencer: step counter, program ROM, conditional jumps.
// Depends on sks_pkg.
`default_nettype none

module sks_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sks_pkg::flags_t flags,
    output sks_pkg::ctrl_t       ctrl,
    output logic                 busy
);

    import sks_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  jump;

    assign ctrl = rom_word(step_reg);
    assign busy = (step_reg != S_IDLE);

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:     jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NOT_START: jump = !flags.start;
            C_CLR_MORE:  jump = flags.clr_more;
            C_OUTER_GT:  jump = flags.outer_gt;
            C_RD_SET:    jump = flags.rd_set;
            C_INNER_GT:  jump = flags.inner_gt;
            C_HIT:       jump = flags.hit;
            default:     jump = 1'b1;
        endcase
        step_next = jump ? ctrl.target : step_t'(step_reg + 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sieve_kth_erased_number.sv
// Top level of the sieve block: datapath, bitmap RAM and sequencer.
// Depends on sks_pkg, sks_seq, sks_ram and the assertion macro header.
//
// Usage:
//   A request (limit, rank) is taken at a rising edge with start high and
//   busy low. busy stays high while the sieve runs.
//   Exactly one result per request: done pulses for one cycle with
//   erased_value and found. Not found gives erased_value 0, found 0.
//   The receiver cannot stall; the result is valid only in the done cycle.
//   A new request may be issued in the done cycle.
//   The run time depends on the limit, on the P primes reached, on the W
//   multiples visited and on the C of them crossed out. The sieve stops
//   early once the rank is hit. The bitmap clear of entries 0 to limit and
//   the single RAM port, one access per step, set this. One request at a
//   time.
//   Reset returns the sequencer to idle; the bitmap needs no reset since
//   each request clears the entries it uses first.
//   The bitmap is one single-port RAM with registered read.
`include "sieve_kth_erased_number_defines.svh"
`default_nettype none

module sieve_kth_erased_number (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [sks_pkg::NUM_W-1:0] limit,
    input  wire logic [sks_pkg::NUM_W-1:0] rank,
    output logic                           done,
    output logic      [sks_pkg::NUM_W-1:0] erased_value,
    output logic                           found
);

    import sks_pkg::*;

    localparam int ADDR_W = $clog2(MAP_DEPTH);

    ctrl_t  ctrl;
    flags_t flags;

    logic [NUM_W-1:0] lim_reg,   lim_next;
    logic [NUM_W-1:0] want_reg,  want_next;
    logic [NUM_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] outer_reg, outer_next;
    logic [IDX_W-1:0] inner_reg, inner_next;
    logic             done_reg,  done_next;
    logic [NUM_W-1:0] value_reg, value_next;
    logic             found_reg, found_next;

    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [0:0]        ram_wdata;
    logic [0:0]        ram_rdata;

    logic [NUM_W-1:0] count_inc;
    logic [IDX_W-1:0] lim_wide;

    sks_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    sks_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign lim_wide  = {1'b0, lim_reg};
    assign count_inc = count_reg + 1'b1;

    assign flags.start    = start;
    assign flags.clr_more = (inner_reg != lim_wide);
    assign flags.outer_gt = (outer_reg > lim_wide);
    assign flags.rd_set   = ram_rdata[0];
    assign flags.inner_gt = (inner_reg > lim_wide);
    assign flags.hit      = (count_inc == want_reg);

    always_comb
    begin
        lim_next   = lim_reg;
        want_next  = want_reg;
        count_next = count_reg;
        outer_next = outer_reg;
        inner_next = inner_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        found_next = found_reg;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = inner_reg[ADDR_W-1:0];
        ram_wdata  = 1'b0;

        unique case (ctrl.op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                if (start)
                begin
                    lim_next   = limit;
                    want_next  = rank;
                    count_next = '0;
                    inner_next = '0;
                end
            end
            OP_CLEAR:
            begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                inner_next = inner_reg + 1'b1;
            end
            OP_OUTER_INIT:
            begin
                outer_next = IDX_W'(2);
            end
            OP_OUTER_SEL:
            begin
                ram_en     = 1'b1;
                ram_addr   = outer_reg[ADDR_W-1:0];
                inner_next = outer_reg;
            end
            OP_INNER_RD:
            begin
                ram_en = 1'b1;
            end
            OP_MARK:
            begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_wdata  = 1'b1;
                count_next = count_inc;
            end
            OP_ADV:
            begin
                inner_next = inner_reg + outer_reg;
            end
            OP_OUTER_INC:
            begin
                outer_next = outer_reg + 1'b1;
            end
            OP_OUT_HIT:
            begin
                done_next  = 1'b1;
                value_next = inner_reg[NUM_W-1:0];
                found_next = 1'b1;
            end
            OP_OUT_NF:
            begin
                done_next  = 1'b1;
                value_next = '0;
                found_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg   <= lim_next;
        want_reg  <= want_next;
        count_reg <= count_next;
        outer_reg <= outer_next;
        inner_reg <= inner_next;
        value_reg <= value_next;
        found_reg <= found_next;
    end

    assign done         = done_reg;
    assign erased_value = value_reg;
    assign found        = found_reg;

    `SKS_ASSERT_NXT(a_done_single, clk, rst_n, done, !done,
        "result strobe longer than one cycle")
    `SKS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy,
        "request taken but not busy")
    `SKS_ASSERT_IMP(a_found_range, clk, rst_n, done && found,
        erased_value >= NUM_W'(2) && erased_value <= lim_reg, "found value outside 2..limit")
    `SKS_ASSERT_IMP(a_write_range, clk, rst_n, ram_we, inner_reg <= lim_wide,
        "bitmap write beyond limit")

endmodule

`default_nettype wire
